/* rtl/core/hexl_pkg.sv */
// Shared types and constants for the hex word loader.
package hexl_pkg;

   // Result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_FUSE   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_SHORT   = 2'd0;
   localparam logic [1:0] ERR_CKSUM   = 2'd1;
   localparam logic [1:0] ERR_ODD     = 2'd2;
   localparam logic [1:0] ERR_NO_END  = 2'd3;

   // Record types
   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;

   // Characters
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] DIGIT_BAD   = 8'hFF;

   localparam logic [14:0] FUSE_WORD  = 15'h2007;
   localparam logic [14:0] PTR_MAX    = 15'h7FFF;
   localparam logic [8:0]  POS_MAX    = 9'd511;
   localparam logic [8:0]  HDR_LEN    = 9'd9;
   localparam int          HIGH_BITS  = 6;
   localparam int          QUEUE_DEPTH = 2;

   // One classified character, as handed from front to back
   typedef struct packed {
      logic [7:0] digit;     // hex value, or all ones if not a hex digit
      logic       is_nl;
      logic       is_colon;
      logic       eoi;
   } token_type;

endpackage

/* rtl/core/hexl_ifs.sv */
// Valid/ready channel interfaces for the hex word loader.
interface hexl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_input;

   modport source (output valid, output character, output end_of_input, input ready);
   modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface hexl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [12:0] word_address;
   logic [13:0] word_data;
   logic        fuse_value;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output word_address, output word_data,
                   output fuse_value, output error_code, input ready);
   modport sink   (input valid, input kind, input word_address, input word_data,
                   input fuse_value, input error_code, output ready);
endinterface

/* rtl/core/hexl_front.sv */
// Front end: takes characters and classifies them into tokens.
module hexl_front (
   hexl_req_if.sink              req_ch,
   output logic                  tok_valid,
   output hexl_pkg::token_type   tok,
   input  logic                  tok_ready
);

   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = hexl_pkg::DIGIT_BAD;
      if (c >= 8'h30 && c <= 8'h39)      v = 8'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 8'(c - 8'h41 + 8'd10);
      else if (c >= 8'h61 && c <= 8'h66) v = 8'(c - 8'h61 + 8'd10);
      return v;
   endfunction

   assign tok_valid    = req_ch.valid;
   assign req_ch.ready = tok_ready;

   always_comb begin
      tok.digit    = digit_value(req_ch.character);
      tok.is_nl    = (req_ch.character == hexl_pkg::CHAR_NL);
      tok.is_colon = (req_ch.character == hexl_pkg::CHAR_COLON);
      tok.eoi      = req_ch.end_of_input;
   end

endmodule

/* rtl/core/hexl_queue.sv */
// Two-entry token queue between front and back.
module hexl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  hexl_pkg::token_type  push_tok,
   output logic                 pop_valid,
   input  logic                 pop,
   output hexl_pkg::token_type  pop_tok
);

   localparam int PW = $clog2(hexl_pkg::QUEUE_DEPTH);

   hexl_pkg::token_type slot_ff [hexl_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != (PW+1)'(hexl_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = (PW+1)'(count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

/* rtl/core/hexl_back.sv */
// Back end: record parser state and the result register.
module hexl_back #(
   parameter int MEM_WORDS = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   input  hexl_pkg::token_type  tok,
   output logic                 tok_pop,
   hexl_rsp_if.source           rsp_ch
);

   logic [8:0]  pos_ff, pos_in;
   logic        lir_ff, lir_in;
   logic [6:0]  pairs_ff, pairs_in;
   logic [7:0]  bc_ff, bc_in;
   logic [7:0]  rt_ff, rt_in;
   logic [14:0] wp_ff, wp_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  hd_ff, hd_in;
   logic [7:0]  lbh_ff, lbh_in;
   logic [13:0] pend_ff, pend_in;
   logic        stop_ff, stop_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [12:0] addr_ff, addr_in;
   logic [13:0] data_ff, data_in;
   logic        fuse_ff, fuse_in;
   logic [1:0]  err_ff, err_in;

   logic        res;
   logic        adv, adv_nl, go;
   logic [7:0]  asm_byte;
   logic [1:0]  phase;
   logic [13:0] word;
   logic [14:0] rel_addr;
   logic [13:0] rel_word;
   logic        rel;

   assign tok_pop  = tok_valid && (!out_valid_ff || rsp_ch.ready);
   assign asm_byte = {hd_ff[3:0], 4'b0000} | tok.digit;

   always_comb begin
      pos_in = pos_ff;  lir_in = lir_ff;  pairs_in = pairs_ff;  bc_in = bc_ff;
      rt_in = rt_ff;    wp_in = wp_ff;    sum_in = sum_ff;      hd_in = hd_ff;
      lbh_in = lbh_ff;  pend_in = pend_ff; stop_in = stop_ff;
      res = 1'b0; kind_in = hexl_pkg::KIND_WRITE; addr_in = '0; data_in = '0;
      fuse_in = 1'b0; err_in = hexl_pkg::ERR_SHORT;
      adv = 1'b0; adv_nl = 1'b0; go = 1'b0; phase = '0; word = '0;
      rel = 1'b0; rel_addr = '0; rel_word = '0;

      if (tok_pop && !stop_ff) begin
         if (tok.eoi) begin
            res = 1'b1; stop_in = 1'b1; kind_in = hexl_pkg::KIND_ERROR;
            err_in = lir_ff ? hexl_pkg::ERR_SHORT : hexl_pkg::ERR_NO_END;
         end else if (!lir_ff) begin
            if (pos_ff == '0 && tok.is_colon) begin
               lir_in = 1'b1; sum_in = '0; wp_in = '0; pairs_in = '0;
            end
            adv = 1'b1; adv_nl = tok.is_nl;
         end else if (pos_ff < hexl_pkg::HDR_LEN) begin
            if (tok.is_nl) begin
               res = 1'b1; stop_in = 1'b1; kind_in = hexl_pkg::KIND_ERROR;
               err_in = hexl_pkg::ERR_SHORT;
            end else begin
               unique case (pos_ff)
                  9'd2: begin
                     bc_in = asm_byte; sum_in = asm_byte;
                  end
                  9'd4: begin
                     wp_in = {asm_byte, 7'b0000000};
                     sum_in = 8'(sum_ff + asm_byte);
                  end
                  9'd6: begin
                     lbh_in = asm_byte;
                     wp_in = wp_ff | {8'b0, asm_byte[7:1]};
                     sum_in = 8'(sum_ff + asm_byte);
                  end
                  9'd8: rt_in = asm_byte;
                  default: hd_in = tok.digit;
               endcase
               adv = 1'b1;
            end
         end else begin
            go = 1'b1;
            if (pos_ff == hexl_pkg::HDR_LEN) begin
               if (rt_ff == hexl_pkg::REC_EOF) begin
                  go = 1'b0; res = 1'b1; stop_in = 1'b1;
                  kind_in = hexl_pkg::KIND_FINISH;
               end else if (rt_ff != hexl_pkg::REC_DATA) begin
                  go = 1'b0; lir_in = 1'b0; adv = 1'b1; adv_nl = tok.is_nl;
               end else if (bc_ff[0] || lbh_ff[0]) begin
                  go = 1'b0; res = 1'b1; stop_in = 1'b1;
                  kind_in = hexl_pkg::KIND_ERROR; err_in = hexl_pkg::ERR_ODD;
               end else begin
                  pairs_in = bc_ff[7:1];
                  bc_in = '0;
               end
            end
            if (go) begin
               if (tok.is_nl) begin
                  res = 1'b1; stop_in = 1'b1; kind_in = hexl_pkg::KIND_ERROR;
                  err_in = hexl_pkg::ERR_SHORT;
               end else begin
                  phase = bc_in[1:0];
                  if (pairs_in == '0) begin
                     if (phase == 2'd0) begin
                        hd_in = tok.digit;
                        bc_in = {5'b0, bc_in[2], 2'b01};
                     end else if (8'(8'd0 - sum_ff) != asm_byte) begin
                        res = 1'b1; stop_in = 1'b1; kind_in = hexl_pkg::KIND_ERROR;
                        err_in = hexl_pkg::ERR_CKSUM;
                     end else begin
                        lir_in = 1'b0;
                        rel = bc_in[2]; rel_addr = wp_ff; rel_word = pend_ff;
                        bc_in = '0;
                     end
                  end else begin
                     unique case (phase)
                        2'd1: begin
                           lbh_in = asm_byte;
                           sum_in = 8'(sum_ff + asm_byte);
                        end
                        2'd3: begin
                           sum_in = 8'(sum_ff + asm_byte);
                           word = {asm_byte[hexl_pkg::HIGH_BITS-1:0], lbh_ff};
                           pairs_in = 7'(pairs_in - 7'd1);
                           if (pairs_in == '0) begin
                              pend_in = word; bc_in = 8'd4;
                           end else begin
                              rel = 1'b1; rel_addr = wp_ff; rel_word = word;
                              if (wp_ff != hexl_pkg::PTR_MAX) wp_in = 15'(wp_ff + 15'd1);
                              bc_in = '0;
                           end
                        end
                        default: hd_in = tok.digit;
                     endcase
                     if (phase != 2'd3) bc_in = {5'b0, bc_in[2], 2'(phase + 2'd1)};
                  end
                  adv = 1'b1;
               end
            end
         end

         if (rel) begin
            if (rel_addr == hexl_pkg::FUSE_WORD) begin
               res = 1'b1; kind_in = hexl_pkg::KIND_FUSE; fuse_in = rel_word[2];
            end else if (rel_addr < 15'(MEM_WORDS)) begin
               res = 1'b1; kind_in = hexl_pkg::KIND_WRITE;
               addr_in = rel_addr[12:0]; data_in = rel_word;
            end
         end

         if (adv) begin
            if (adv_nl) begin
               pos_in = '0; lir_in = 1'b0;
            end else if (pos_ff != hexl_pkg::POS_MAX) begin
               pos_in = 9'(pos_ff + 9'd1);
            end
         end
      end

      if (tok_pop && res)              out_valid_in = 1'b1;
      else if (rsp_ch.ready)           out_valid_in = 1'b0;
      else                             out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; lir_ff <= 1'b0; pairs_ff <= '0; bc_ff <= '0; rt_ff <= '0;
         wp_ff <= '0; sum_ff <= '0; hd_ff <= '0; lbh_ff <= '0; pend_ff <= '0;
         stop_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; lir_ff <= lir_in; pairs_ff <= pairs_in; bc_ff <= bc_in;
         rt_ff <= rt_in; wp_ff <= wp_in; sum_ff <= sum_in; hd_ff <= hd_in;
         lbh_ff <= lbh_in; pend_ff <= pend_in; stop_ff <= stop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && res) begin
         kind_ff <= kind_in; addr_ff <= addr_in; data_ff <= data_in;
         fuse_ff <= fuse_in; err_ff <= err_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.word_address = addr_ff;
   assign rsp_ch.word_data    = data_ff;
   assign rsp_ch.fuse_value   = fuse_ff;
   assign rsp_ch.error_code   = err_ff;

endmodule

/* rtl/core/intel_hex_word_loader_top.sv */
// Top level of the hex word loader: front, token queue and parser back end.
//
//   channel  | dir | payload                                            | transfer
//   ---------+-----+----------------------------------------------------+------------------
//   req_ch   | in  | character[7:0], end_of_input                       | valid && ready
//   rsp_ch   | out | kind, word_address, word_data, fuse_value, err code| valid && ready
//
// While rsp_ch does not stall, one character is taken per cycle; the parser back
// end retires one queued token per cycle, so the sustained rate is one character per clock.
// A character's result passes through the token queue and then the parser,
// whose result register drives rsp_ch.
// A stalled rsp_ch holds the result register; the back end then stops popping,
// and the two-entry queue keeps req_ch ready until it fills.
// Reset is synchronous and active high; it clears the queue, the parser state
// and the result valid. After a finish or error result all later input is
// taken and dropped.
module intel_hex_word_loader_top #(
   parameter int MEM_WORDS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   hexl_req_if.sink    req_ch,
   hexl_rsp_if.source  rsp_ch
);

   // Classified character from the front end
   logic                 fr_valid;
   logic                 fr_ready;
   hexl_pkg::token_type  fr_tok;

   // Head of the queue as seen by the back end
   logic                 q_valid;
   logic                 q_pop;
   hexl_pkg::token_type  q_tok;

   // Decode digit, newline, colon and end marker
   hexl_front u_front (
      .req_ch    (req_ch),
      .tok_valid (fr_valid),
      .tok       (fr_tok),
      .tok_ready (fr_ready)
   );

   // Decouple input transfers from result stalls
   hexl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_tok   (fr_tok),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_tok    (q_tok)
   );

   // Advance the record parser and register its result
   hexl_back #(
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_valid),
      .tok       (q_tok),
      .tok_pop   (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* rtl/core/hexl_checker.sv */
// Port-level checks for the hex word loader, bound to the top level.
module hexl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [12:0] word_address,
   input logic [13:0] word_data,
   input logic        fuse_value,
   input logic [1:0]  error_code
);

   logic done_ff, done_in;

   assign done_in = done_ff || (rsp_valid && rsp_ready &&
                    (kind == hexl_pkg::KIND_FINISH || kind == hexl_pkg::KIND_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !rsp_valid)
      else $error("result after finish or error");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(word_data))
      else $error("result changed while stalled");

   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == hexl_pkg::KIND_WRITE |->
         !fuse_value && error_code == hexl_pkg::ERR_SHORT)
      else $error("stray fields on word write");

   a_other_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != hexl_pkg::KIND_WRITE |-> word_address == '0 && word_data == '0)
      else $error("stray word fields on non-write result");

endmodule

bind intel_hex_word_loader_top hexl_checker u_hexl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .kind         (rsp_ch.kind),
   .word_address (rsp_ch.word_address),
   .word_data    (rsp_ch.word_data),
   .fuse_value   (rsp_ch.fuse_value),
   .error_code   (rsp_ch.error_code)
);

/* tb/intel_hex_word_loader_checker.sv */
`timescale 1ns / 100ps
// Checker for the hex word loader: predicts each result from the accepted characters.
module intel_hex_word_loader_checker
   import hexl_pkg::*;
#(
   parameter int MEM_WORDS = 8192
) (
   input  logic clock,
   input  logic reset,
   hexl_req_if  req_mon,
   hexl_rsp_if  rsp_mon,
   output int   mismatches,
   output int   results_due
);

   localparam logic [8:0] POS_COUNT    = 9'd2;
   localparam logic [8:0] POS_ADDR_HI  = 9'd4;
   localparam logic [8:0] POS_ADDR_LO  = 9'd6;
   localparam logic [8:0] POS_REC_TYPE = 9'd8;
   localparam int         REPORT_MAX   = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] word_address;
      logic [13:0] word_data;
      logic        fuse_value;
      logic [1:0]  error_code;
   } loader_result_type;

   // Parser state
   logic [8:0]  line_pos;
   logic        in_record;
   logic [6:0]  pairs_left;
   logic [7:0]  byte_count;
   logic [7:0]  rec_type;
   logic [14:0] word_ptr;
   logic [7:0]  run_sum;
   logic [7:0]  hi_digit;
   logic [7:0]  low_hold;
   logic [13:0] pend_word;
   logic        halted;

   loader_result_type loader_results_q[$];
   int                bad_count = 0;

   function automatic logic [7:0] nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return ch - "0";
      if (ch >= "A" && ch <= "F") return ch - "A" + 8'd10;
      if (ch >= "a" && ch <= "f") return ch - "a" + 8'd10;
      return DIGIT_BAD;
   endfunction

   function automatic logic [7:0] join_digits(input logic [7:0] hi, input logic [7:0] lo);
      return {hi[3:0], 4'h0} | lo;
   endfunction

   task automatic queue_result(input logic [1:0] kind, input logic [12:0] addr,
                               input logic [13:0] data, input logic fuse,
                               input logic [1:0] code);
      loader_result_type r;
      r.kind         = kind;
      r.word_address = addr;
      r.word_data    = data;
      r.fuse_value   = fuse;
      r.error_code   = code;
      loader_results_q.push_back(r);
   endtask

   task automatic stop_with_error(input logic [1:0] code);
      halted = 1'b1;
      queue_result(KIND_ERROR, '0, '0, 1'b0, code);
   endtask

   task automatic release_word(input logic [14:0] addr, input logic [13:0] w);
      if (addr == FUSE_WORD)
         queue_result(KIND_FUSE, '0, '0, w[2], '0);
      else if (addr < MEM_WORDS)
         queue_result(KIND_WRITE, addr[12:0], w, 1'b0, '0);
   endtask

   task automatic next_position(input logic nl);
      if (nl) begin
         line_pos  = '0;
         in_record = 1'b0;
      end else if (line_pos < POS_MAX) begin
         line_pos = line_pos + 9'd1;
      end
   endtask

   task automatic parse_char(input logic [7:0] ch, input logic eoi);
      logic [7:0]  v;
      logic [7:0]  b;
      logic [1:0]  phase;
      logic [13:0] w;
      logic        nl;
      logic [8:0]  p;
      if (halted) return;
      if (eoi) begin
         stop_with_error(in_record ? ERR_SHORT : ERR_NO_END);
         return;
      end
      nl = (ch == CHAR_NL);
      p  = line_pos;

      if (!in_record) begin
         if (p == '0 && ch == CHAR_COLON) begin
            in_record  = 1'b1;
            run_sum    = '0;
            word_ptr   = '0;
            pairs_left = '0;
         end
         next_position(nl);
         return;
      end

      v = nibble_of(ch);
      if (p < HDR_LEN) begin
         if (nl) begin
            stop_with_error(ERR_SHORT);
            return;
         end
         case (p)
            POS_COUNT: begin
               byte_count = join_digits(hi_digit, v);
               run_sum    = byte_count;
            end
            POS_ADDR_HI: begin
               b        = join_digits(hi_digit, v);
               word_ptr = {b, 7'b0};
               run_sum  = run_sum + b;
            end
            POS_ADDR_LO: begin
               b        = join_digits(hi_digit, v);
               low_hold = b;
               word_ptr = word_ptr | {8'b0, b[7:1]};
               run_sum  = run_sum + b;
            end
            POS_REC_TYPE: rec_type = join_digits(hi_digit, v);
            default:      hi_digit = v;
         endcase
         next_position(1'b0);
         return;
      end

      // header complete: act on the record type
      if (p == HDR_LEN) begin
         if (rec_type == REC_EOF) begin
            halted = 1'b1;
            queue_result(KIND_FINISH, '0, '0, 1'b0, '0);
            return;
         end
         if (rec_type != REC_DATA) begin
            in_record = 1'b0;
            next_position(nl);
            return;
         end
         if (byte_count[0] || low_hold[0]) begin
            stop_with_error(ERR_ODD);
            return;
         end
         pairs_left = byte_count[7:1];
         byte_count = '0;
      end

      if (nl) begin
         stop_with_error(ERR_SHORT);
         return;
      end
      phase = byte_count[1:0];

      if (pairs_left == '0) begin
         // checksum byte
         if (phase == 2'd0) begin
            hi_digit   = v;
            byte_count = {5'b0, byte_count[2], 2'b01};
         end else begin
            b = join_digits(hi_digit, v);
            if (b != 8'(8'h00 - run_sum)) begin
               stop_with_error(ERR_CKSUM);
               return;
            end
            in_record = 1'b0;
            if (byte_count[2]) release_word(word_ptr, pend_word);
            byte_count = '0;
         end
      end else begin
         case (phase)
            2'd1: begin
               low_hold = join_digits(hi_digit, v);
               run_sum  = run_sum + low_hold;
            end
            2'd3: begin
               b          = join_digits(hi_digit, v);
               run_sum    = run_sum + b;
               w          = {b[5:0], low_hold};
               pairs_left = pairs_left - 7'd1;
               if (pairs_left == '0) begin
                  pend_word  = w;
                  byte_count = 8'd4;
               end else begin
                  release_word(word_ptr, w);
                  if (word_ptr < PTR_MAX) word_ptr = word_ptr + 15'd1;
               end
            end
            default: hi_digit = v;
         endcase
         if (phase != 2'd3) byte_count = {5'b0, byte_count[2], phase + 2'd1};
         else if (pairs_left != '0) byte_count = '0;
      end
      next_position(1'b0);
   endtask

   always @(posedge clock) begin
      loader_result_type got;
      loader_result_type want;
      if (reset) begin
         line_pos   = '0;
         in_record  = 1'b0;
         pairs_left = '0;
         byte_count = '0;
         rec_type   = '0;
         word_ptr   = '0;
         run_sum    = '0;
         hi_digit   = '0;
         low_hold   = '0;
         pend_word  = '0;
         halted     = 1'b0;
         loader_results_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            parse_char(req_mon.character, req_mon.end_of_input);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind         = rsp_mon.kind;
            got.word_address = rsp_mon.word_address;
            got.word_data    = rsp_mon.word_data;
            got.fuse_value   = rsp_mon.fuse_value;
            got.error_code   = rsp_mon.error_code;
            if (loader_results_q.size() == 0) begin
               bad_count++;
               if (bad_count <= REPORT_MAX)
                  $display("%t unexpected result: kind=%0d addr=%h data=%h fuse=%0d err=%0d",
                           $time, got.kind, got.word_address, got.word_data,
                           got.fuse_value, got.error_code);
            end else begin
               want = loader_results_q.pop_front();
               if (got.kind != want.kind || got.word_address != want.word_address ||
                   got.word_data != want.word_data || got.fuse_value != want.fuse_value ||
                   got.error_code != want.error_code) begin
                  bad_count++;
                  if (bad_count <= REPORT_MAX) begin
                     $display("%t result mismatch", $time);
                     $display("   expected kind=%0d addr=%h data=%h fuse=%0d err=%0d",
                              want.kind, want.word_address, want.word_data,
                              want.fuse_value, want.error_code);
                     $display("   actual   kind=%0d addr=%h data=%h fuse=%0d err=%0d",
                              got.kind, got.word_address, got.word_data,
                              got.fuse_value, got.error_code);
                  end
               end
            end
         end
      end
      mismatches  <= bad_count;
      results_due <= loader_results_q.size();
   end

endmodule

/* tb/intel_hex_word_loader_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the hex word loader: clock, reset, hex text stimulus and verdict.
module intel_hex_word_loader_top_tb;
   import hexl_pkg::*;

   localparam int MEM_WORDS     = 8192;
   localparam int ITEM_TARGET   = 1410;  // characters sent before the closing part
   localparam int IDLE_PCT      = 28;
   localparam int HOLD_CYCLES   = 200;   // long result stall to back up the input
   localparam int HOLD_AT       = 800;
   localparam int DRAIN_AT      = 1000;
   localparam int CALM_FROM     = 1050;
   localparam int CALM_TO       = 1300;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 20;

   // How the stream ends; the first report stops the block, so only one per run
   typedef enum int {
      END_RECORD, EOI_IDLE, EOI_IN_LINE, SHORT_HEADER,
      TRUNCATED, BAD_CHECKSUM, ODD_COUNT, ODD_ADDRESS
   } ending_type;

   logic       clock;
   logic       reset;
   int         mismatches;
   int         results_due;
   int         chars_sent;
   logic       calm;       // no idling on either side while set
   logic       hold_rsp;   // ask the receiver for its one long stall
   logic [7:0] data_script[$];

   hexl_req_if req_ch();
   hexl_rsp_if rsp_ch();

   intel_hex_word_loader_top #(
      .MEM_WORDS (MEM_WORDS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   intel_hex_word_loader_checker #(
      .MEM_WORDS (MEM_WORDS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // Receiver: random back-pressure, one long hold-off counted here, none while calm
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_rsp && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic bit is_hex_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [7:0] any_char_but_nl();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CHAR_NL);
      return c;
   endfunction

   // a character that decodes as a bad digit
   function automatic logic [7:0] junk_digit();
      logic [7:0] c;
      do c = any_char_but_nl(); while (is_hex_digit(c));
      return c;
   endfunction

   // hex digit in random letter case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   // favor bytes that can be spelled with bad digits
   function automatic logic [7:0] rand_data_byte();
      case ($urandom_range(9))
         0:       return 8'hFF;
         1:       return {4'hF, 4'($urandom_range(15))};
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one character and hold it until the transfer; idle first at random
   task automatic send_char(input logic [7:0] ch, input logic eoi);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_ch.valid        <= 1'b1;
      req_ch.character    <= ch;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
   endtask

   // Send two characters that form the given byte. A bad high digit still gives
   // 0xF? and a bad low digit gives 0xFF, so those spellings keep the value.
   task automatic send_hex_byte(input logic [7:0] value, input bit junk_ok);
      logic [7:0] hi;
      logic [7:0] lo;
      if (junk_ok && value == 8'hFF && $urandom_range(3) == 0) begin
         hi = $urandom_range(1) ? junk_digit() : hex_char(4'hF);
         lo = junk_digit();
      end else if (junk_ok && value[7:4] == 4'hF && $urandom_range(3) == 0) begin
         hi = junk_digit();
         lo = hex_char(value[3:0]);
      end else begin
         hi = hex_char(value[7:4]);
         lo = hex_char(value[3:0]);
      end
      send_char(hi, 1'b0);
      send_char(lo, 1'b0);
   endtask

   // Data record; data from data_script if loaded, else random. ck_flip spoils the
   // checksum; cut_at >= 0 ends the line early after that many bytes.
   task automatic send_data_record(input logic [15:0] addr, input int nbytes, input int tail,
                                   input logic [7:0] ck_flip, input int cut_at);
      logic [7:0] sum;
      logic [7:0] value;
      sum = 8'(nbytes) + addr[15:8] + addr[7:0];
      send_char(CHAR_COLON, 1'b0);
      send_hex_byte(8'(nbytes), 1'b1);
      send_hex_byte(addr[15:8], 1'b1);
      send_hex_byte(addr[7:0], 1'b1);
      send_hex_byte(REC_DATA, 1'b0);
      for (int k = 0; k <= nbytes; k++) begin
         if (k == cut_at) begin
            if ($urandom_range(1)) send_char(hex_char(4'($urandom)), 1'b0);
            send_char(CHAR_NL, 1'b0);
            return;
         end
         if (k == nbytes) begin
            send_hex_byte(8'(8'h00 - sum) ^ ck_flip, 1'b1);
         end else begin
            value = (data_script.size() > 0) ? data_script.pop_front() : rand_data_byte();
            sum   = sum + value;
            send_hex_byte(value, 1'b1);
         end
      end
      repeat (tail) send_char(any_char_but_nl(), 1'b0);
      send_char(CHAR_NL, 1'b0);
   endtask

   // Record of a type the block skips; tail 0 puts the newline right after the header
   task automatic send_other_record(input int tail);
      logic [7:0] rtype;
      do rtype = 8'($urandom); while (rtype == REC_DATA || rtype == REC_EOF);
      send_char(CHAR_COLON, 1'b0);
      repeat (3) send_hex_byte(8'($urandom), 1'b1);
      send_hex_byte(rtype, 1'b1);
      repeat (tail) send_char(any_char_but_nl(), 1'b0);
      send_char(CHAR_NL, 1'b0);
   endtask

   // Line that does not open with a colon; colons inside it must be ignored
   task automatic send_noise_line(input int len);
      logic [7:0] c;
      do c = any_char_but_nl(); while (c == CHAR_COLON);
      send_char(c, 1'b0);
      repeat (len) send_char(($urandom_range(7) == 0) ? CHAR_COLON : any_char_but_nl(), 1'b0);
      send_char(CHAR_NL, 1'b0);
   endtask

   task automatic send_blank_line();
      send_char(CHAR_NL, 1'b0);
   endtask

   // Drop valid and wait for every predicted result to arrive
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   initial begin
      int          done;
      int          word;
      int          nbytes;
      int          pick;
      int          wait_cycles;
      bit          drained;
      bit          stuck;
      logic [15:0] addr;
      ending_type  ending;

      reset               <= 1'b1;
      calm                <= 1'b0;
      hold_rsp            <= 1'b0;
      req_ch.valid        <= 1'b0;
      req_ch.character    <= '0;
      req_ch.end_of_input <= 1'b0;
      chars_sent    = 0;
      drained       = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_noise_line(12);
      send_blank_line();
      // all-zero words; high bits of the second word fall outside the 14-bit word
      data_script = '{8'h00, 8'h00, 8'h00, 8'hC0};
      send_data_record(16'h0000, 4, 0, 8'h00, -1);
      // last two memory words, all ones, spelled partly with bad digits
      data_script = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_data_record(16'h3FFC, 4, 2, 8'h00, -1);
      // fuse word inside a record (released at once), neighbors beyond memory
      data_script = '{8'h12, 8'h34, 8'h04, 8'h3F, 8'h56, 8'h78};
      send_data_record(16'h400C, 6, 0, 8'h00, -1);
      // fuse word as the last word, released after the checksum, fuse cleared
      data_script = '{8'hFB, 8'hFF};
      send_data_record(16'h400E, 2, 0, 8'h00, -1);
      // zero-length data record: checksum check only, trailing characters
      send_data_record(16'h1234, 0, 1, 8'h00, -1);
      // skipped record types, one ending right after the header
      send_other_record(5);
      send_other_record(0);
      // word pointer runs into saturation
      send_data_record(16'hFFF0, 32, 0, 8'h00, -1);
      // largest even count; the line runs past the position limit
      send_data_record(16'h0100, 254, 3, 8'h00, -1);

      // ---- random part: mostly well-formed records ----
      while (chars_sent < ITEM_TARGET) begin
         done = chars_sent;
         if (done >= HOLD_AT) hold_rsp <= 1'b1;
         if (done >= DRAIN_AT && !drained) begin
            drained = 1'b1;
            wait_for_drain();
         end
         calm <= (done >= CALM_FROM && done < CALM_TO);
         pick = $urandom_range(99);
         if (pick < 72) begin
            nbytes = 2 * (($urandom_range(39) == 0) ? $urandom_range(127) : $urandom_range(12));
            case ($urandom_range(19))
               0, 1:    word = $urandom_range(16'h2000, 16'h200A);
               2, 3:    word = $urandom_range(MEM_WORDS, 16'h7FFF);
               4:       word = $urandom_range(16'h7F00, 16'h7FFF);
               default: word = $urandom_range(MEM_WORDS - 1);
            endcase
            addr = 16'(word << 1);
            send_data_record(addr, nbytes, ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0,
                             8'h00, -1);
         end else if (pick < 82) begin
            send_other_record($urandom_range(8));
         end else if (pick < 94) begin
            send_noise_line($urandom_range(20));
         end else begin
            send_blank_line();
         end
      end
      calm <= 1'b0;

      // ---- closing: one end record or one error stops the block ----
      ending = ending_type'($urandom_range(7));
      addr   = 16'($urandom_range(MEM_WORDS - 1) << 1);
      case (ending)
         END_RECORD: begin
            send_char(CHAR_COLON, 1'b0);
            repeat (3) send_hex_byte(8'($urandom), 1'b1);
            send_hex_byte(REC_EOF, 1'b0);
            if ($urandom_range(1)) send_hex_byte(8'($urandom), 1'b1);
            send_char(CHAR_NL, 1'b0);
         end
         EOI_IDLE: begin
            send_data_record(addr, 4, 0, 8'h00, -1);
            send_char(8'($urandom), 1'b1);
         end
         EOI_IN_LINE: begin
            send_char(CHAR_COLON, 1'b0);
            repeat ($urandom_range(8)) send_char(hex_char(4'($urandom)), 1'b0);
            send_char(8'($urandom), 1'b1);
         end
         SHORT_HEADER: begin
            send_char(CHAR_COLON, 1'b0);
            repeat ($urandom_range(7)) send_char(any_char_but_nl(), 1'b0);
            send_char(CHAR_NL, 1'b0);
         end
         TRUNCATED: begin
            nbytes = 2 * $urandom_range(1, 6);
            send_data_record(addr, nbytes, 0, 8'h00, $urandom_range(nbytes));
         end
         BAD_CHECKSUM: begin
            send_data_record(addr, 2 * $urandom_range(6), 0, 8'(1 << $urandom_range(7)), -1);
         end
         ODD_COUNT: begin
            send_data_record(addr, 2 * $urandom_range(6) + 1, 0, 8'h00, -1);
         end
         default: begin
            send_data_record(addr | 16'h0001, 2 * $urandom_range(1, 6), 0, 8'h00, -1);
         end
      endcase

      // the block is stopped now; all of this must be dropped silently
      send_data_record(16'h0040, 4, 0, 8'h00, -1);
      send_char(8'($urandom), 1'b1);

      // Drain, then give the pipeline time to show any stray result
      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (results_due != 0 && wait_cycles < DRAIN_LIMIT);
      stuck = (results_due != 0);
      if (stuck) $display("%t results never arrived: %0d", $time, results_due);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && !stuck) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
